/* rtl/bik_pkg.sv */
package bik_pkg;

   localparam int POS_W      = 18;
   localparam int DIFF_W     = 19;
   localparam int ANG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] REG_LINK_LENGTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LATERAL_OFFSET   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HIP_OFFSET_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HIP_OFFSET_Y_MAG = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HIP_OFFSET_Z     = 3'd4;

   localparam int ONE_Q16        = 65536;
   localparam int HALF_PI_Q16    = 102944;
   localparam int PI_Q16         = 205887;
   localparam int VERT_FLOOR_Q32 = 42950;
   localparam int CORDIC_STEPS   = 17;

   localparam int RATIO_W    = 18;
   localparam int ANGLE_W    = 19;
   localparam int XY_W       = 27;
   localparam int DIV_NUM_W  = 20;
   localparam int DIV_DEN_W  = 19;
   localparam int DIV_QB     = 18;
   localparam int DIV_LAT    = DIV_QB + 2;
   localparam int ASIN_RAD_W = 33;

   typedef logic signed [RATIO_W-1:0] ratio_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dy;
      logic                     side;
      logic                     dx_pos;
      logic                     dx_neg;
      logic signed [ANG_W-1:0]  ankle;
   } side_info_type;

   function automatic int sqrt_out_w(input int w);
      return (w + 1) >> 1;
   endfunction

   localparam int ASIN_LAT = 1 + sqrt_out_w(ASIN_RAD_W) + CORDIC_STEPS;

   function automatic logic [16:0] atan_q16(input int unsigned i);
      logic [16:0] v;
      case (i)
         0:       v = 17'd51472;
         1:       v = 17'd30385;
         2:       v = 17'd16055;
         3:       v = 17'd8150;
         4:       v = 17'd4091;
         5:       v = 17'd2047;
         6:       v = 17'd1024;
         7:       v = 17'd512;
         8:       v = 17'd256;
         9:       v = 17'd128;
         10:      v = 17'd64;
         11:      v = 17'd32;
         12:      v = 17'd16;
         13:      v = 17'd8;
         14:      v = 17'd4;
         15:      v = 17'd2;
         16:      v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/biped_leg_inverse_kinematics_top.sv */
// biped leg inverse kinematics
// input words arrive on start with req_* fields: desired foot position (Q2.16 m),
// leg select and the measured hip pitch and knee angles (Q3.12 rad).
// a word is taken at a clock edge with start high and busy low; busy is high only
// during reset, so one word can be taken every clock.
// each word gives one result word on rsp_*: hip roll, hip pitch, knee and ankle
// angles in Q3.12 rad, marked by rsp_valid for exactly one cycle.
// from the taking edge to rsp_valid a word passes, in order, through the registers
// of offset, square and sum, the distance square roots, the ratio dividers, the
// arcsine units (square, root and 17 cordic rotations) and the registers for
// angle sums and rounding.
// throughput is one word per clock; words never interact.
// the csr_* port writes the five geometry registers; they must only change while
// the pipeline is empty. reset restores the default geometry and empties the
// pipeline. the receiver cannot hold results off and the pipeline never stalls.
module biped_leg_inverse_kinematics_top
   import bik_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [POS_W-1:0]      req_foot_x,
   input  logic signed [POS_W-1:0]      req_foot_y,
   input  logic signed [POS_W-1:0]      req_foot_z,
   input  logic                         req_leg_side,
   input  logic signed [ANG_W-1:0]      req_meas_hip_pitch,
   input  logic signed [ANG_W-1:0]      req_meas_knee,
   output logic                         rsp_valid,
   output logic signed [ANG_W-1:0]      rsp_hip_roll_angle,
   output logic signed [ANG_W-1:0]      rsp_hip_pitch_angle,
   output logic signed [ANG_W-1:0]      rsp_knee_angle,
   output logic signed [ANG_W-1:0]      rsp_ankle_angle,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int SQ_IN_W  = 38;
   localparam int SQ_LAT   = sqrt_out_w(SQ_IN_W);
   localparam int SQ_W     = sqrt_out_w(SQ_IN_W);
   localparam int SUM_W    = 22;
   localparam int TAP_DIV  = SQ_LAT + 2;
   localparam int DL_LEN   = SQ_LAT + DIV_LAT + ASIN_LAT + 3;

   localparam logic signed [SUM_W-1:0] HALF_PI_S = SUM_W'(HALF_PI_Q16);
   localparam logic signed [SUM_W-1:0] PI_S      = SUM_W'(PI_Q16);
   localparam logic signed [SUM_W-1:0] OUT_MAX   = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] OUT_MIN   = -SUM_W'(32768);
   localparam ratio_type                RATIO_ONE = RATIO_W'(ONE_Q16);

   // geometry registers
   logic [15:0]              link_length_ff;
   logic [15:0]              lateral_offset_ff;
   logic signed [POS_W-1:0]  hip_offset_x_ff;
   logic [15:0]              hip_offset_y_mag_ff;
   logic signed [POS_W-1:0]  hip_offset_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_length_ff      <= 16'd14418;
         lateral_offset_ff   <= 16'd1343;
         hip_offset_x_ff     <= 18'sd3047;
         hip_offset_y_mag_ff <= 16'd1311;
         hip_offset_z_ff     <= -18'sd12911;
      end else if (csr_we) begin
         case (csr_index)
            REG_LINK_LENGTH:      link_length_ff      <= csr_data[15:0];
            REG_LATERAL_OFFSET:   lateral_offset_ff   <= csr_data[15:0];
            REG_HIP_OFFSET_X:     hip_offset_x_ff     <= $signed(csr_data);
            REG_HIP_OFFSET_Y_MAG: hip_offset_y_mag_ff <= csr_data[15:0];
            REG_HIP_OFFSET_Z:     hip_offset_z_ff     <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // stage 1: offsets and ankle
   logic                     v1_ff;
   logic signed [DIFF_W-1:0] dx_ff;
   logic signed [DIFF_W-1:0] dz_ff;
   side_info_type            side_ff;

   logic                     v1_in;
   logic signed [DIFF_W-1:0] dx_in;
   logic signed [DIFF_W-1:0] dz_in;
   logic signed [DIFF_W-1:0] yoff;
   logic signed [16:0]       meas_sum;
   logic signed [17:0]       ankle_full;
   side_info_type            side_in;

   always_comb begin
      v1_in = start && !busy;
      dx_in = DIFF_W'(req_foot_x) - DIFF_W'(hip_offset_x_ff);
      dz_in = DIFF_W'(req_foot_z) - DIFF_W'(hip_offset_z_ff);
      yoff  = $signed(DIFF_W'(hip_offset_y_mag_ff));
      side_in.dy     = req_leg_side ? DIFF_W'(req_foot_y) - yoff
                                    : DIFF_W'(req_foot_y) + yoff;
      side_in.side   = req_leg_side;
      side_in.dx_pos = dx_in > 0;
      side_in.dx_neg = dx_in < 0;
      meas_sum   = 17'(req_meas_knee) + 17'(req_meas_hip_pitch);
      ankle_full = -18'(meas_sum);
      if (ankle_full > 18'sd32767) begin
         side_in.ankle = 16'sh7fff;
      end else if (ankle_full < -18'sd32768) begin
         side_in.ankle = -16'sh8000;
      end else begin
         side_in.ankle = ankle_full[ANG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      dx_ff   <= dx_in;
      dz_ff   <= dz_in;
      side_ff <= side_in;
   end

   // stage 2: squares
   logic                       v2_ff;
   logic [2*DIFF_W-2:0]        dxsq_ff;
   logic [2*DIFF_W-2:0]        dysq_ff;
   logic [2*DIFF_W-2:0]        dzsq_ff;
   logic signed [2*DIFF_W-1:0] dx_prod;
   logic signed [2*DIFF_W-1:0] dy_prod;
   logic signed [2*DIFF_W-1:0] dz_prod;

   assign dx_prod = dx_ff * dx_ff;
   assign dy_prod = side_ff.dy * side_ff.dy;
   assign dz_prod = dz_ff * dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      dxsq_ff <= dx_prod[2*DIFF_W-2:0];
      dysq_ff <= dy_prod[2*DIFF_W-2:0];
      dzsq_ff <= dz_prod[2*DIFF_W-2:0];
   end

   // stage 3: distance sums
   logic               v3_ff;
   logic [SQ_IN_W-1:0] yozsq_ff;
   logic [SQ_IN_W-1:0] d3sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      yozsq_ff <= SQ_IN_W'(dysq_ff) + SQ_IN_W'(dzsq_ff);
      d3sq_ff  <= SQ_IN_W'(dxsq_ff) + SQ_IN_W'(dysq_ff) + SQ_IN_W'(dzsq_ff);
   end

   // stage 4: lateral offset removed, vertical floor
   logic [31:0]                h2;
   logic signed [SQ_IN_W:0]    vdiff;
   logic signed [SQ_IN_W:0]    xdiff;
   logic                       v4_ff;
   logic [SQ_IN_W-1:0]         vsq_ff;
   logic [SQ_IN_W-1:0]         xozsq_ff;
   logic [SQ_IN_W-1:0]         yozsq4_ff;
   logic [SQ_IN_W-1:0]         vsq_in;
   logic [SQ_IN_W-1:0]         xozsq_in;

   always_comb begin
      h2    = lateral_offset_ff * lateral_offset_ff;
      vdiff = $signed({1'b0, yozsq_ff}) - $signed((SQ_IN_W + 1)'(h2));
      xdiff = $signed({1'b0, d3sq_ff}) - $signed((SQ_IN_W + 1)'(h2));
      if (vdiff < $signed((SQ_IN_W + 1)'(VERT_FLOOR_Q32))) begin
         vsq_in = SQ_IN_W'(VERT_FLOOR_Q32);
      end else begin
         vsq_in = vdiff[SQ_IN_W-1:0];
      end
      if (xdiff <= 0) begin
         xozsq_in = '0;
      end else begin
         xozsq_in = xdiff[SQ_IN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      vsq_ff    <= vsq_in;
      xozsq_ff  <= xozsq_in;
      yozsq4_ff <= yozsq_ff;
   end

   // side data travelling alongside the arithmetic
   side_info_type dl_ff [DL_LEN];

   always_ff @(posedge clock) begin
      dl_ff[0] <= side_ff;
      for (int k = 1; k < DL_LEN; k++) begin
         dl_ff[k] <= dl_ff[k-1];
      end
   end

   // square roots
   logic            sq_yoz_v, sq_vert_v, sq_xoz_v;
   logic [SQ_W-1:0] yoz, vert, xoz;

   bik_sqrt #(.IN_W(SQ_IN_W)) u_sqrt_yoz (
      .clock(clock), .reset(reset), .in_valid(v4_ff), .in_rad(yozsq4_ff),
      .out_valid(sq_yoz_v), .out_root(yoz)
   );

   bik_sqrt #(.IN_W(SQ_IN_W)) u_sqrt_vert (
      .clock(clock), .reset(reset), .in_valid(v4_ff), .in_rad(vsq_ff),
      .out_valid(sq_vert_v), .out_root(vert)
   );

   bik_sqrt #(.IN_W(SQ_IN_W)) u_sqrt_xoz (
      .clock(clock), .reset(reset), .in_valid(v4_ff), .in_rad(xozsq_ff),
      .out_valid(sq_xoz_v), .out_root(xoz)
   );

   // ratios
   side_info_type               tap_div;
   logic signed [DIV_NUM_W-1:0] num_a1, num_a2, num_t1, num_t2;
   logic [DIV_DEN_W-1:0]        den_a1;
   logic                        dv_a1, dv_a2, dv_t1, dv_t2;
   ratio_type                   a1, a2, t1, t2;

   always_comb begin
      tap_div = dl_ff[TAP_DIV];
      num_a1  = $signed(DIV_NUM_W'(xoz));
      num_a2  = $signed(DIV_NUM_W'(vert));
      num_t1  = DIV_NUM_W'(tap_div.dy);
      num_t2  = tap_div.side ? $signed(DIV_NUM_W'(lateral_offset_ff))
                             : -$signed(DIV_NUM_W'(lateral_offset_ff));
      den_a1  = DIV_DEN_W'({link_length_ff, 1'b0});
   end

   bik_div u_div_a1 (
      .clock(clock), .reset(reset), .in_valid(sq_yoz_v), .in_num(num_a1),
      .in_den(den_a1), .out_valid(dv_a1), .out_ratio(a1)
   );

   bik_div u_div_a2 (
      .clock(clock), .reset(reset), .in_valid(sq_yoz_v), .in_num(num_a2),
      .in_den(xoz), .out_valid(dv_a2), .out_ratio(a2)
   );

   bik_div u_div_t1 (
      .clock(clock), .reset(reset), .in_valid(sq_yoz_v), .in_num(num_t1),
      .in_den(yoz), .out_valid(dv_t1), .out_ratio(t1)
   );

   bik_div u_div_t2 (
      .clock(clock), .reset(reset), .in_valid(sq_yoz_v), .in_num(num_t2),
      .in_den(yoz), .out_valid(dv_t2), .out_ratio(t2)
   );

   // arcsines
   logic      av_a1, av_a2, av_t1, av_t2;
   angle_type as_a1, as_a2, as_t1, as_t2;

   bik_asin u_asin_a1 (
      .clock(clock), .reset(reset), .in_valid(dv_t1), .in_r(a1),
      .out_valid(av_a1), .out_angle(as_a1)
   );

   bik_asin u_asin_a2 (
      .clock(clock), .reset(reset), .in_valid(dv_t1), .in_r(a2),
      .out_valid(av_a2), .out_angle(as_a2)
   );

   bik_asin u_asin_t1 (
      .clock(clock), .reset(reset), .in_valid(dv_t1), .in_r(t1),
      .out_valid(av_t1), .out_angle(as_t1)
   );

   bik_asin u_asin_t2 (
      .clock(clock), .reset(reset), .in_valid(dv_t1), .in_r(t2),
      .out_valid(av_t2), .out_angle(as_t2)
   );

   // joint angle sums
   side_info_type             tap_out;
   logic signed [SUM_W-1:0]   acos1, acos2, pitch_term;
   logic                      cv_ff;
   logic signed [SUM_W-1:0]   roll_ff, pitch_ff, knee_ff;
   logic signed [ANG_W-1:0]   ankle_ff;

   always_comb begin
      tap_out = dl_ff[DL_LEN-1];
      acos1   = HALF_PI_S - SUM_W'(as_a1);
      acos2   = HALF_PI_S - SUM_W'(as_a2);
      if (tap_out.dx_pos) begin
         pitch_term = acos2;
      end else if (tap_out.dx_neg) begin
         pitch_term = -acos2;
      end else begin
         pitch_term = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= 1'b0;
      end else begin
         cv_ff <= av_t1;
      end
      roll_ff  <= SUM_W'(as_t1) + SUM_W'(as_t2);
      pitch_ff <= acos1 - pitch_term;
      knee_ff  <= (SUM_W'(as_a1) <<< 1) - PI_S;
      ankle_ff <= tap_out.ankle;
   end

   // rounding to Q3.12 with saturation
   function automatic logic signed [ANG_W-1:0] to_out(input logic signed [SUM_W-1:0] q);
      logic signed [SUM_W-1:0] r;
      logic signed [ANG_W-1:0] o;
      r = (q + SUM_W'(8)) >>> 4;
      if (r > OUT_MAX) begin
         o = 16'sh7fff;
      end else if (r < OUT_MIN) begin
         o = -16'sh8000;
      end else begin
         o = r[ANG_W-1:0];
      end
      return o;
   endfunction

   logic                    rsp_valid_ff;
   logic signed [ANG_W-1:0] rsp_roll_ff, rsp_pitch_ff, rsp_knee_ff, rsp_ankle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cv_ff;
      end
      rsp_roll_ff  <= to_out(roll_ff);
      rsp_pitch_ff <= to_out(pitch_ff);
      rsp_knee_ff  <= to_out(knee_ff);
      rsp_ankle_ff <= ankle_ff;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hip_roll_angle  = rsp_roll_ff;
   assign rsp_hip_pitch_angle = rsp_pitch_ff;
   assign rsp_knee_angle      = rsp_knee_ff;
   assign rsp_ankle_angle     = rsp_ankle_ff;

   // parallel lanes stay in lock step
   assert property (@(posedge clock) disable iff (reset)
      (sq_vert_v == sq_yoz_v) && (sq_xoz_v == sq_yoz_v))
      else $error("square root lanes out of step");

   assert property (@(posedge clock) disable iff (reset)
      (dv_a1 == dv_t1) && (dv_a2 == dv_t1) && (dv_t2 == dv_t1))
      else $error("divider lanes out of step");

   assert property (@(posedge clock) disable iff (reset)
      (av_a1 == av_t1) && (av_a2 == av_t1) && (av_t2 == av_t1))
      else $error("arcsine lanes out of step");

   assert property (@(posedge clock) disable iff (reset)
      dv_t1 |-> (a1 >= 0 && a1 <= RATIO_ONE && a2 >= 0 && a2 <= RATIO_ONE
                 && t1 >= -RATIO_ONE && t1 <= RATIO_ONE
                 && t2 >= -RATIO_ONE && t2 <= RATIO_ONE))
      else $error("ratio outside unit range");

endmodule

/* rtl/bik_sqrt.sv */
module bik_sqrt
   import bik_pkg::*;
#(
   parameter int IN_W = 38
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [IN_W-1:0]              in_rad,
   output logic                         out_valid,
   output logic [sqrt_out_w(IN_W)-1:0]  out_root
);

   localparam int OUT_W = sqrt_out_w(IN_W);
   localparam int PAD_W = 2 * OUT_W;
   localparam int REM_W = OUT_W + 2;

   logic             v_ff    [OUT_W];
   logic [PAD_W-1:0] rad_ff  [OUT_W];
   logic [REM_W-1:0] rem_ff  [OUT_W];
   logic [OUT_W-1:0] root_ff [OUT_W];

   for (genvar s = 0; s < OUT_W; s++) begin : g_stage
      logic             v_src;
      logic [PAD_W-1:0] rad_src;
      logic [REM_W-1:0] rem_src;
      logic [OUT_W-1:0] root_src;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             take;
      logic             v_in;
      logic [PAD_W-1:0] rad_in;
      logic [REM_W-1:0] rem_in;
      logic [OUT_W-1:0] root_in;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign rad_src  = PAD_W'(in_rad);
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign v_src    = v_ff[s-1];
         assign rad_src  = rad_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
      end

      always_comb begin
         rem_sh  = {rem_src[REM_W-3:0], rad_src[PAD_W-1 -: 2]};
         trial   = {root_src, 2'b01};
         take    = rem_sh >= trial;
         v_in    = v_src;
         rad_in  = rad_src << 2;
         rem_in  = take ? rem_sh - trial : rem_sh;
         root_in = {root_src[OUT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_in;
         end
         rad_ff[s]  <= rad_in;
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
      end
   end

   assign out_valid = v_ff[OUT_W-1];
   assign out_root  = root_ff[OUT_W-1];

endmodule

/* rtl/bik_div.sv */
module bik_div
   import bik_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [DIV_NUM_W-1:0] in_num,
   input  logic [DIV_DEN_W-1:0]        in_den,
   output logic                        out_valid,
   output ratio_type                   out_ratio
);

   localparam int N_W   = DIV_NUM_W + 16;
   localparam int CMP_W = DIV_DEN_W + DIV_QB + 1;
   localparam logic [DIV_QB-1:0] Q_ONE = DIV_QB'(ONE_Q16);
   localparam logic [16:0]       M_ONE = 17'(ONE_Q16);

   logic                 s_v_ff;
   logic [N_W-1:0]       s_rem_ff;
   logic [DIV_DEN_W-1:0] s_den_ff;
   logic                 s_neg_ff;
   logic                 s_sat_ff;
   logic                 s_zero_ff;

   logic                 s_v_in;
   logic [N_W-1:0]       s_rem_in;
   logic                 s_neg_in;
   logic                 s_sat_in;
   logic                 s_zero_in;
   logic [DIV_NUM_W-1:0] mag;

   always_comb begin
      s_neg_in  = in_num[DIV_NUM_W-1];
      mag       = s_neg_in ? DIV_NUM_W'(-in_num) : DIV_NUM_W'(in_num);
      s_rem_in  = {mag, 16'b0};
      s_sat_in  = CMP_W'(s_rem_in) >= (CMP_W'(in_den) << DIV_QB);
      s_zero_in = in_den == '0;
      s_v_in    = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_v_ff <= 1'b0;
      end else begin
         s_v_ff <= s_v_in;
      end
      s_rem_ff  <= s_rem_in;
      s_den_ff  <= in_den;
      s_neg_ff  <= s_neg_in;
      s_sat_ff  <= s_sat_in;
      s_zero_ff <= s_zero_in;
   end

   logic                 v_ff    [DIV_QB];
   logic [N_W-1:0]       rem_ff  [DIV_QB];
   logic [DIV_QB-1:0]    q_ff    [DIV_QB];
   logic [DIV_DEN_W-1:0] den_ff  [DIV_QB];
   logic                 neg_ff  [DIV_QB];
   logic                 sat_ff  [DIV_QB];
   logic                 zero_ff [DIV_QB];

   for (genvar j = 0; j < DIV_QB; j++) begin : g_bit
      localparam int K = DIV_QB - 1 - j;
      logic                 v_src;
      logic [N_W-1:0]       rem_src;
      logic [DIV_QB-1:0]    q_src;
      logic [DIV_DEN_W-1:0] den_src;
      logic                 neg_src;
      logic                 sat_src;
      logic                 zero_src;
      logic [CMP_W-1:0]     shifted;
      logic                 take;
      logic [N_W-1:0]       rem_in;
      logic [DIV_QB-1:0]    q_in;

      if (j == 0) begin : g_first
         assign v_src    = s_v_ff;
         assign rem_src  = s_rem_ff;
         assign q_src    = '0;
         assign den_src  = s_den_ff;
         assign neg_src  = s_neg_ff;
         assign sat_src  = s_sat_ff;
         assign zero_src = s_zero_ff;
      end else begin : g_next
         assign v_src    = v_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign q_src    = q_ff[j-1];
         assign den_src  = den_ff[j-1];
         assign neg_src  = neg_ff[j-1];
         assign sat_src  = sat_ff[j-1];
         assign zero_src = zero_ff[j-1];
      end

      always_comb begin
         shifted = CMP_W'(den_src) << K;
         take    = CMP_W'(rem_src) >= shifted;
         rem_in  = take ? N_W'(CMP_W'(rem_src) - shifted) : rem_src;
         q_in    = take ? (q_src | (DIV_QB'(1) << K)) : q_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_src;
         end
         rem_ff[j]  <= rem_in;
         q_ff[j]    <= q_in;
         den_ff[j]  <= den_src;
         neg_ff[j]  <= neg_src;
         sat_ff[j]  <= sat_src;
         zero_ff[j] <= zero_src;
      end
   end

   logic      out_v_ff;
   ratio_type ratio_ff;
   ratio_type ratio_in;
   logic [16:0] mag_r;

   always_comb begin
      if (zero_ff[DIV_QB-1] || sat_ff[DIV_QB-1] || q_ff[DIV_QB-1] >= Q_ONE) begin
         mag_r = M_ONE;
      end else begin
         mag_r = q_ff[DIV_QB-1][16:0];
      end
      if (neg_ff[DIV_QB-1] && !zero_ff[DIV_QB-1]) begin
         ratio_in = -$signed(RATIO_W'(mag_r));
      end else begin
         ratio_in = $signed(RATIO_W'(mag_r));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= v_ff[DIV_QB-1];
      end
      ratio_ff <= ratio_in;
   end

   assign out_valid = out_v_ff;
   assign out_ratio = ratio_ff;

endmodule

/* rtl/bik_asin.sv */
module bik_asin
   import bik_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  ratio_type in_r,
   output logic      out_valid,
   output angle_type out_angle
);

   localparam int SQ_LAT = sqrt_out_w(ASIN_RAD_W);
   localparam logic [ASIN_RAD_W-1:0] ONE_SQ = ASIN_RAD_W'(1) << 32;

   logic                   a_v_ff;
   ratio_type              a_r_ff;
   logic                   a_zero_ff;
   logic [ASIN_RAD_W-1:0]  a_rsq_ff;
   logic signed [2*RATIO_W-1:0] prod;
   logic [ASIN_RAD_W-1:0]  a_rsq_in;
   logic                   a_zero_in;

   always_comb begin
      prod      = in_r * in_r;
      a_rsq_in  = prod[ASIN_RAD_W-1:0];
      a_zero_in = in_r == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= in_valid;
      end
      a_r_ff    <= in_r;
      a_zero_ff <= a_zero_in;
      a_rsq_ff  <= a_rsq_in;
   end

   logic                  sq_v;
   logic [SQ_LAT-1:0]     sq_root;
   logic [ASIN_RAD_W-1:0] rad;

   assign rad = ONE_SQ - a_rsq_ff;

   bik_sqrt #(
      .IN_W(ASIN_RAD_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (a_v_ff),
      .in_rad   (rad),
      .out_valid(sq_v),
      .out_root (sq_root)
   );

   ratio_type dr_ff    [SQ_LAT];
   logic      dzero_ff [SQ_LAT];

   always_ff @(posedge clock) begin
      dr_ff[0]    <= a_r_ff;
      dzero_ff[0] <= a_zero_ff;
      for (int k = 1; k < SQ_LAT; k++) begin
         dr_ff[k]    <= dr_ff[k-1];
         dzero_ff[k] <= dzero_ff[k-1];
      end
   end

   logic                   cv_ff [CORDIC_STEPS];
   logic signed [XY_W-1:0] x_ff  [CORDIC_STEPS];
   logic signed [XY_W-1:0] y_ff  [CORDIC_STEPS];
   angle_type              z_ff  [CORDIC_STEPS];
   logic                   cz_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      localparam angle_type ATAN_I = angle_type'(atan_q16(i));
      logic                   v_src;
      logic signed [XY_W-1:0] x_src;
      logic signed [XY_W-1:0] y_src;
      angle_type              z_src;
      logic                   zero_src;
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [XY_W-1:0] x_in;
      logic signed [XY_W-1:0] y_in;
      angle_type              z_in;

      if (i == 0) begin : g_first
         assign v_src    = sq_v;
         assign x_src    = $signed(XY_W'(sq_root)) <<< 8;
         assign y_src    = XY_W'(dr_ff[SQ_LAT-1]) <<< 8;
         assign z_src    = '0;
         assign zero_src = dzero_ff[SQ_LAT-1];
      end else begin : g_next
         assign v_src    = cv_ff[i-1];
         assign x_src    = x_ff[i-1];
         assign y_src    = y_ff[i-1];
         assign z_src    = z_ff[i-1];
         assign zero_src = cz_ff[i-1];
      end

      always_comb begin
         xs = x_src >>> i;
         ys = y_src >>> i;
         if (y_src > 0) begin
            x_in = x_src + ys;
            y_in = y_src - xs;
            z_in = z_src + ATAN_I;
         end else begin
            x_in = x_src - ys;
            y_in = y_src + xs;
            z_in = z_src - ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i] <= 1'b0;
         end else begin
            cv_ff[i] <= v_src;
         end
         x_ff[i]  <= x_in;
         y_ff[i]  <= y_in;
         z_ff[i]  <= z_in;
         cz_ff[i] <= zero_src;
      end
   end

   assign out_valid = cv_ff[CORDIC_STEPS-1];
   assign out_angle = cz_ff[CORDIC_STEPS-1] ? '0 : z_ff[CORDIC_STEPS-1];

endmodule
